>>> sv/acesc_pkg.sv
// ----------------------------------------------------------------------------
// ANSI escape to screen cells - shared package
// Field widths, character codes, result kinds and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package acesc_pkg;

    localparam int GLYPH_W = 21;
    localparam int POS_W   = 10;
    localparam int PARAM_W = 10;
    localparam int ADDR_W  = 14;
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 8;
    localparam int COLR_W  = 3;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 8;

    localparam int MAX_PARAMS_DEF = 10;
    localparam int MAX_DIGITS_DEF = 3;

    localparam logic [PARAM_W-1:0] PARAM_CAP = 10'd999;

    localparam logic [GLYPH_W-1:0] CH_NUL   = 21'h00;
    localparam logic [GLYPH_W-1:0] CH_ESC   = 21'h1B;
    localparam logic [GLYPH_W-1:0] CH_CR    = 21'h0D;
    localparam logic [GLYPH_W-1:0] CH_LF    = 21'h0A;
    localparam logic [GLYPH_W-1:0] CH_QUERY = 21'h3F;
    localparam logic [GLYPH_W-1:0] CH_SEMI  = 21'h3B;
    localparam logic [GLYPH_W-1:0] CH_ZERO  = 21'h30;
    localparam logic [GLYPH_W-1:0] CH_NINE  = 21'h39;
    localparam logic [GLYPH_W-1:0] CH_UP_H  = 21'h48;
    localparam logic [GLYPH_W-1:0] CH_LO_F  = 21'h66;
    localparam logic [GLYPH_W-1:0] CH_UP_A  = 21'h41;
    localparam logic [GLYPH_W-1:0] CH_UP_F  = 21'h46;
    localparam logic [GLYPH_W-1:0] CH_UP_B  = 21'h42;
    localparam logic [GLYPH_W-1:0] CH_UP_E  = 21'h45;
    localparam logic [GLYPH_W-1:0] CH_UP_C  = 21'h43;
    localparam logic [GLYPH_W-1:0] CH_UP_D  = 21'h44;
    localparam logic [GLYPH_W-1:0] CH_LO_S  = 21'h73;
    localparam logic [GLYPH_W-1:0] CH_LO_U  = 21'h75;
    localparam logic [GLYPH_W-1:0] CH_UP_G  = 21'h47;
    localparam logic [GLYPH_W-1:0] CH_UP_J  = 21'h4A;
    localparam logic [GLYPH_W-1:0] CH_LO_M  = 21'h6D;
    localparam logic [GLYPH_W-1:0] CH_LO_H  = 21'h68;
    localparam logic [GLYPH_W-1:0] CH_LO_L  = 21'h6C;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [1:0] PH_GROUND = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    localparam logic CFG_ROWS    = 1'b0;
    localparam logic CFG_COLUMNS = 1'b1;

    localparam logic [ROWS_W-1:0] ROWS_RST = 7'd25;
    localparam logic [COLS_W-1:0] COLS_RST = 8'd80;
    localparam logic [COLR_W-1:0] FORE_RST = 3'd7;
    localparam logic [COLR_W-1:0] BACK_RST = 3'd0;

    typedef struct packed {
        logic load;
        logic exec;
        logic sgr_step;
        logic put_mul;
        logic put_fin;
        logic out_adv;
    } t_cmd;

    typedef struct packed {
        logic is_put;
        logic is_sgr;
        logic walk_zero;
        logic out_last;
    } t_stat;

endpackage

>>> sv/acesc_ctrl.sv
// ----------------------------------------------------------------------------
// ANSI escape controller
// Sequences one glyph: accept, execute, optional SGR walk or cell write
// steps, then one output beat per result, or a single status beat if none.
// ----------------------------------------------------------------------------
module acesc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  acesc_pkg::t_stat  i_stat,
    output acesc_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SGR  = 3'd2;
    localparam logic [2:0] ST_PUT1 = 3'd3;
    localparam logic [2:0] ST_PUT2 = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_stat.is_put)      n_state = ST_PUT1;
                else if (i_stat.is_sgr) n_state = ST_SGR;
                else                    n_state = ST_OUT;
            end
            ST_SGR:  if (i_stat.walk_zero) n_state = ST_OUT;
            ST_PUT1: n_state = ST_PUT2;
            ST_PUT2: n_state = ST_OUT;
            ST_OUT:  if (!i_out_stall && i_stat.out_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = (r_state == ST_OUT);
    assign o_cmd.load     = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.exec     = (r_state == ST_EXEC);
    assign o_cmd.sgr_step = (r_state == ST_SGR) && !i_stat.walk_zero;
    assign o_cmd.put_mul  = (r_state == ST_PUT1);
    assign o_cmd.put_fin  = (r_state == ST_PUT2);
    assign o_cmd.out_adv  = (r_state == ST_OUT) && !i_out_stall;

endmodule

>>> sv/acesc_dp.sv
// ----------------------------------------------------------------------------
// ANSI escape datapath
// Parser registers, parameter store, cursor and attribute state, screen
// size registers, cell address arithmetic and the two result slots.
// ----------------------------------------------------------------------------
module acesc_dp #(
    parameter int MAX_PARAMS = acesc_pkg::MAX_PARAMS_DEF,
    parameter int MAX_DIGITS = acesc_pkg::MAX_DIGITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [acesc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [acesc_pkg::GLYPH_W-1:0]      i_glyph_code,
    input  acesc_pkg::t_cmd                    i_cmd,
    output acesc_pkg::t_stat                   o_stat,
    output logic [acesc_pkg::KIND_W-1:0]       o_kind,
    output logic [acesc_pkg::ADDR_W-1:0]       o_cell_address,
    output logic [acesc_pkg::GLYPH_W-1:0]      o_glyph,
    output logic [acesc_pkg::PARAM_W-1:0]      o_attribute,
    output logic [acesc_pkg::COLR_W-1:0]       o_fore_colour,
    output logic [acesc_pkg::COLR_W-1:0]       o_back_colour,
    output logic [acesc_pkg::POS_W-1:0]        o_max_row,
    output logic                               o_last
);

    localparam int PCW = $clog2(MAX_PARAMS + 1);
    localparam int PIW = $clog2(MAX_PARAMS);
    localparam int DCW = $clog2(MAX_DIGITS + 1);
    localparam int GW  = acesc_pkg::GLYPH_W;
    localparam int PW  = acesc_pkg::POS_W;
    localparam int VW  = acesc_pkg::PARAM_W;
    localparam int AW  = acesc_pkg::ADDR_W;
    localparam int KW  = acesc_pkg::KIND_W;
    localparam int CLW = acesc_pkg::COLR_W;
    localparam int RW  = acesc_pkg::ROWS_W;
    localparam int CW  = acesc_pkg::COLS_W;

    localparam logic [PCW-1:0] PC_MAX = PCW'(MAX_PARAMS);
    localparam logic [DCW-1:0] DC_MAX = DCW'(MAX_DIGITS);

    logic [GW-1:0]  r_glyph;
    logic [1:0]     r_phase;
    logic [VW-1:0]  r_ps [MAX_PARAMS];
    logic [PCW-1:0] r_pc;
    logic [DCW-1:0] r_dc;
    logic           r_had;
    logic           r_first;
    logic [PW-1:0]  r_col, r_row, r_used;
    logic [VW-1:0]  r_attr;
    logic [CLW-1:0] r_fore, r_back;
    logic [PW-1:0]  r_scol, r_srow;
    logic [VW-1:0]  r_sattr;
    logic [CLW-1:0] r_sfore, r_sback;
    logic [RW-1:0]  r_rows;
    logic [CW-1:0]  r_cols;
    logic signed [19:0] r_prod;
    logic [RW+CW-1:0]   r_area;
    logic [PCW-1:0] r_walk;
    logic [1:0]     r_rcnt;
    logic           r_oidx;
    logic [KW-1:0]  r_kind  [2];
    logic [AW-1:0]  r_addr  [2];
    logic [GW-1:0]  r_rglyph[2];

    logic           w_digit;
    logic [VW-1:0]  w_cur;
    logic [13:0]    w_acc;
    logic [VW-1:0]  w_dval;
    logic [PCW-1:0] w_pfin;
    logic [PW:0]    w_row_inc;
    logic [PW-1:0]  w_rows_ext;
    logic [PW-1:0]  w_cols_ext;
    logic [PW:0]    w_sum_row, w_sum_col;
    logic signed [PW:0] w_rm1;
    logic signed [20:0] w_pos;
    logic           w_pos_ok;
    logic [VW-1:0]  w_p0;

    assign w_digit    = (r_glyph >= acesc_pkg::CH_ZERO) && (r_glyph <= acesc_pkg::CH_NINE);
    assign w_cur      = r_ps[r_pc[PIW-1:0]];
    // value times ten by shifts, then add the digit
    assign w_acc      = (r_dc == '0) ? 14'(r_glyph[3:0])
                      : ({w_cur, 3'b000} + {3'b000, w_cur, 1'b0} + 14'(r_glyph[3:0]));
    assign w_dval     = (w_acc > 14'(acesc_pkg::PARAM_CAP)) ? acesc_pkg::PARAM_CAP
                                                              : w_acc[VW-1:0];
    assign w_pfin     = (r_had && (r_pc < PC_MAX)) ? r_pc + 1'b1 : r_pc;
    assign w_row_inc  = {1'b0, r_row} + 1'b1;
    assign w_rows_ext = PW'(r_rows);
    assign w_cols_ext = PW'(r_cols);
    assign w_p0       = r_ps[0];
    assign w_sum_row  = {1'b0, r_row} + {1'b0, w_p0};
    assign w_sum_col  = {1'b0, r_col} + {1'b0, w_p0};
    assign w_rm1      = $signed({1'b0, r_row}) - 11'sd1;
    assign w_pos      = 21'(r_prod) + $signed({11'b0, r_col}) - 21'sd1;
    assign w_pos_ok   = !w_pos[20] && (w_pos < $signed({6'b0, r_area}));

    assign o_stat.is_put = (r_phase == acesc_pkg::PH_GROUND)
                        && (r_glyph != acesc_pkg::CH_ESC) && (r_glyph != acesc_pkg::CH_CR)
                        && (r_glyph != acesc_pkg::CH_LF) && (r_glyph != acesc_pkg::CH_NUL);
    assign o_stat.is_sgr    = (r_phase == acesc_pkg::PH_CSI) && (r_glyph == acesc_pkg::CH_LO_M);
    assign o_stat.walk_zero = (r_walk == '0);
    assign o_stat.out_last  = (r_rcnt == 2'd0) || ({1'b0, r_oidx} == r_rcnt - 2'd1);

    assign o_kind         = r_kind[r_oidx];
    assign o_cell_address = r_addr[r_oidx];
    assign o_glyph        = r_rglyph[r_oidx];
    assign o_attribute    = r_attr;
    assign o_fore_colour  = r_fore;
    assign o_back_colour  = r_back;
    assign o_max_row      = r_used;
    assign o_last         = o_stat.out_last;

    // payload registers: captured glyph, product, area and result slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_glyph     <= i_glyph_code;
            r_kind[0]   <= acesc_pkg::KIND_STATUS;
            r_addr[0]   <= '0;
            r_rglyph[0] <= '0;
        end
        if (i_cmd.put_mul) begin
            r_prod <= 20'(w_rm1) * 20'($signed({1'b0, r_cols}));
            r_area <= r_rows * r_cols;
        end
        if (i_cmd.exec) begin
            // any result from this step lands in the first slot
            if (r_phase == acesc_pkg::PH_GROUND) begin
                if ((r_glyph != acesc_pkg::CH_ESC) && (r_glyph != acesc_pkg::CH_NUL)
                    && ((r_glyph == acesc_pkg::CH_LF) ? (w_row_inc > {1'b0, w_rows_ext})
                                                      : (r_row > w_rows_ext))) begin
                    r_kind[0] <= acesc_pkg::KIND_SCROLL;
                end
            end else if ((r_phase == acesc_pkg::PH_CSI) && (r_glyph == acesc_pkg::CH_UP_J)
                         && !(w_digit && (r_dc < DC_MAX)) && (w_p0 == 10'd2)) begin
                r_kind[0] <= acesc_pkg::KIND_CLEAR;
            end
        end
        if (i_cmd.put_fin && w_pos_ok) begin
            r_kind[r_rcnt[0]]   <= acesc_pkg::KIND_WRITE;
            r_addr[r_rcnt[0]]   <= w_pos[AW-1:0];
            r_rglyph[r_rcnt[0]] <= r_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= acesc_pkg::PH_GROUND;
            for (int i = 0; i < MAX_PARAMS; i++) r_ps[i] <= '0;
            r_pc    <= '0;
            r_dc    <= '0;
            r_had   <= 1'b0;
            r_first <= 1'b0;
            r_col   <= PW'(1);
            r_row   <= PW'(1);
            r_used  <= PW'(1);
            r_attr  <= '0;
            r_fore  <= acesc_pkg::FORE_RST;
            r_back  <= acesc_pkg::BACK_RST;
            r_scol  <= PW'(1);
            r_srow  <= PW'(1);
            r_sattr <= '0;
            r_sfore <= acesc_pkg::FORE_RST;
            r_sback <= acesc_pkg::BACK_RST;
            r_rows  <= acesc_pkg::ROWS_RST;
            r_cols  <= acesc_pkg::COLS_RST;
            r_walk  <= '0;
            r_rcnt  <= '0;
            r_oidx  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    acesc_pkg::CFG_ROWS:    r_rows <= i_cfg_data[RW-1:0];
                    acesc_pkg::CFG_COLUMNS: r_cols <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_rcnt <= '0;
                r_oidx <= 1'b0;
            end

            if (i_cmd.out_adv) begin
                r_oidx <= 1'b1;
            end

            if (i_cmd.exec) begin
                unique case (r_phase)
                    acesc_pkg::PH_ESC: r_phase <= acesc_pkg::PH_CSI;
                    acesc_pkg::PH_CSI: begin
                        if (w_digit && (r_dc < DC_MAX)) begin
                            if (r_pc < PC_MAX) r_ps[r_pc[PIW-1:0]] <= w_dval;
                            r_dc  <= r_dc + 1'b1;
                            r_had <= 1'b1;
                        end else if (r_glyph == acesc_pkg::CH_QUERY) begin
                            r_had <= 1'b0;
                            r_dc  <= '0;
                        end else if (r_glyph == acesc_pkg::CH_SEMI) begin
                            if (!r_had) r_first <= 1'b1;
                            if (r_pc < PC_MAX) r_pc <= r_pc + 1'b1;
                            r_had <= 1'b0;
                            r_dc  <= '0;
                        end else begin
                            r_pc    <= w_pfin;
                            r_phase <= acesc_pkg::PH_GROUND;
                            priority if ((r_glyph == acesc_pkg::CH_UP_H)
                                         || (r_glyph == acesc_pkg::CH_LO_F)) begin
                                if (w_pfin == '0) begin
                                    r_col <= PW'(1);
                                    r_row <= PW'(1);
                                end else if (w_pfin == PCW'(1)) begin
                                    r_col <= PW'(1);
                                    r_row <= w_p0;
                                end else if (r_first) begin
                                    r_col <= r_ps[1];
                                end else begin
                                    r_col <= r_ps[1];
                                    r_row <= w_p0;
                                end
                            end else if ((r_glyph == acesc_pkg::CH_UP_A)
                                         || (r_glyph == acesc_pkg::CH_UP_F)) begin
                                if (w_pfin == '0) begin
                                    if (r_row > PW'(1)) r_row <= r_row - 1'b1;
                                end else begin
                                    r_row <= (r_row > w_p0) ? r_row - w_p0 : PW'(1);
                                end
                            end else if ((r_glyph == acesc_pkg::CH_UP_B)
                                         || (r_glyph == acesc_pkg::CH_UP_E)) begin
                                if (w_pfin == '0) begin
                                    if (r_row < w_rows_ext) r_row <= r_row + 1'b1;
                                end else begin
                                    r_row <= (w_sum_row > {1'b0, w_rows_ext}) ? w_rows_ext
                                                                              : w_sum_row[PW-1:0];
                                end
                            end else if (r_glyph == acesc_pkg::CH_UP_C) begin
                                if (w_pfin == '0) begin
                                    if (r_col < w_cols_ext) r_col <= r_col + 1'b1;
                                end else begin
                                    r_col <= (w_sum_col > {1'b0, w_cols_ext}) ? w_cols_ext
                                                                              : w_sum_col[PW-1:0];
                                end
                            end else if (r_glyph == acesc_pkg::CH_UP_D) begin
                                if (w_pfin == '0) begin
                                    if (r_col > PW'(1)) r_col <= r_col - 1'b1;
                                end else begin
                                    r_col <= (r_col > w_p0) ? r_col - w_p0 : PW'(1);
                                end
                            end else if (r_glyph == acesc_pkg::CH_LO_S) begin
                                r_scol  <= r_col;
                                r_srow  <= r_row;
                                r_sattr <= r_attr;
                                r_sfore <= r_fore;
                                r_sback <= r_back;
                            end else if (r_glyph == acesc_pkg::CH_LO_U) begin
                                r_col  <= r_scol;
                                r_row  <= r_srow;
                                r_attr <= r_sattr;
                                r_fore <= r_sfore;
                                r_back <= r_sback;
                            end else if (r_glyph == acesc_pkg::CH_UP_G) begin
                                r_col <= (w_pfin == '0) ? PW'(1) : w_p0;
                            end else if (r_glyph == acesc_pkg::CH_UP_J) begin
                                if (w_p0 == 10'd2) begin
                                    r_col  <= PW'(1);
                                    r_row  <= PW'(1);
                                    r_used <= PW'(1);
                                    r_rcnt <= 2'd1;
                                end
                            end else if (r_glyph == acesc_pkg::CH_LO_M) begin
                                if (w_pfin == '0) begin
                                    r_attr <= '0;
                                    r_fore <= acesc_pkg::FORE_RST;
                                    r_back <= acesc_pkg::BACK_RST;
                                end
                                r_walk <= w_pfin;
                            end else begin
                                // unknown final: drop
                            end
                        end
                    end
                    default: begin
                        if (r_glyph == acesc_pkg::CH_ESC) begin
                            r_phase <= acesc_pkg::PH_ESC;
                            for (int i = 0; i < MAX_PARAMS; i++) r_ps[i] <= '0;
                            r_pc    <= '0;
                            r_dc    <= '0;
                            r_had   <= 1'b0;
                            r_first <= 1'b0;
                        end else if (r_glyph == acesc_pkg::CH_CR) begin
                            r_col <= PW'(1);
                            if (r_used < r_row) r_used <= r_row;
                            if (r_row > w_rows_ext) begin
                                r_row  <= w_rows_ext;
                                r_rcnt <= 2'd1;
                            end
                        end else if (r_glyph == acesc_pkg::CH_LF) begin
                            if ({1'b0, r_used} < w_row_inc) r_used <= w_row_inc[PW-1:0];
                            if (w_row_inc > {1'b0, w_rows_ext}) begin
                                r_row  <= w_rows_ext;
                                r_rcnt <= 2'd1;
                            end else begin
                                r_row <= w_row_inc[PW-1:0];
                            end
                        end else if (r_glyph != acesc_pkg::CH_NUL) begin
                            // raise the high-water row, or scroll and pin it
                            if (r_row > w_rows_ext) begin
                                r_row  <= w_rows_ext;
                                r_used <= w_rows_ext;
                                r_rcnt <= 2'd1;
                            end else if (r_used < r_row) begin
                                r_used <= r_row;
                            end
                        end
                    end
                endcase
            end

            if (i_cmd.sgr_step) begin
                if (w_p0 == '0) begin
                    r_attr <= '0;
                    r_fore <= acesc_pkg::FORE_RST;
                    r_back <= acesc_pkg::BACK_RST;
                end else if ((w_p0 >= 10'd30) && (w_p0 <= 10'd37)) begin
                    r_fore <= CLW'(w_p0 - 10'd30);
                end else if ((w_p0 >= 10'd40) && (w_p0 <= 10'd47)) begin
                    r_back <= CLW'(w_p0 - 10'd40);
                end else begin
                    r_attr <= w_p0;
                end
                // shift the next parameter down to the head
                for (int i = 0; i < MAX_PARAMS - 1; i++) r_ps[i] <= r_ps[i+1];
                r_ps[MAX_PARAMS-1] <= '0;
                r_walk <= r_walk - 1'b1;
            end

            if (i_cmd.put_fin) begin
                if (w_pos_ok) r_rcnt <= r_rcnt + 2'd1;
                if (r_col >= w_cols_ext) begin
                    r_col <= PW'(1);
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/ansi_escape_to_screen_cells.sv
// ----------------------------------------------------------------------------
// ANSI escape to screen cells
// CSI escape parser turning a glyph stream into cell writes, scrolls and
// clears, with cursor, SGR colour and attribute tracking.
// ----------------------------------------------------------------------------
// Sequence: a glyph is accepted, then executed; a printable glyph then takes a
// multiply step and a finish step, an SGR final with n parameters walks them
// (one per cycle). Throughput: one glyph at a time; the next is taken once
// every result beat (one or two) has left.
// Reset: synchronous, active low; screen is 25 by 80, cursor at 1,1.
module ansi_escape_to_screen_cells #(
    parameter int MAX_PARAMS = acesc_pkg::MAX_PARAMS_DEF,
    parameter int MAX_DIGITS = acesc_pkg::MAX_DIGITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [acesc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [acesc_pkg::GLYPH_W-1:0]      i_glyph_code,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [acesc_pkg::KIND_W-1:0]       o_kind,
    output logic [acesc_pkg::ADDR_W-1:0]       o_cell_address,
    output logic [acesc_pkg::GLYPH_W-1:0]      o_glyph,
    output logic [acesc_pkg::PARAM_W-1:0]      o_attribute,
    output logic [acesc_pkg::COLR_W-1:0]       o_fore_colour,
    output logic [acesc_pkg::COLR_W-1:0]       o_back_colour,
    output logic [acesc_pkg::POS_W-1:0]        o_max_row,
    output logic                               o_last
);

    acesc_pkg::t_cmd  w_cmd;
    acesc_pkg::t_stat w_stat;

    acesc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    acesc_dp #(
        .MAX_PARAMS (MAX_PARAMS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_glyph_code   (i_glyph_code),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_kind         (o_kind),
        .o_cell_address (o_cell_address),
        .o_glyph        (o_glyph),
        .o_attribute    (o_attribute),
        .o_fore_colour  (o_fore_colour),
        .o_back_colour  (o_back_colour),
        .o_max_row      (o_max_row),
        .o_last         (o_last)
    );

endmodule
